// File: rtl/core/pmux_pkg.sv
package pmux_pkg;

    localparam int NUM_SLOTS = 4;
    localparam int NUM_VALS  = 5;
    localparam int DRIVE_W   = 16;
    localparam int DATA_W    = NUM_VALS * DRIVE_W;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int SRC_W     = 2;
    localparam int FUNC_W    = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_STORE   = 2'd0,
        FUNC_TICK    = 2'd1,
        FUNC_PUBLISH = 2'd2
    } t_func;

    localparam int CFG_PRIO_BASE = 0;
    localparam int CFG_TMO_BASE  = 4;

    localparam logic signed [CFG_W-1:0] PRIO_RESET [NUM_SLOTS] = '{
        16'sd100, 16'sd50, 16'sd10, 16'sd0
    };
    localparam logic [CFG_W-1:0] TMO_RESET [NUM_SLOTS] = '{
        16'd250, 16'd500, 16'd500, 16'd500
    };

    typedef struct packed {
        logic                   store;
        logic                   tick;
        logic [SRC_W-1:0]       src;
        logic                   cfg_we;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CFG_W-1:0]       cfg_data;
    } t_bus;

    typedef struct packed {
        logic                   vld;
        logic signed [CFG_W-1:0] prio;
        logic [SRC_W-1:0]       idx;
        logic [DATA_W-1:0]      data;
    } t_cand;

endpackage

// File: rtl/core/pmux_cell.sv
module pmux_cell
    import pmux_pkg::*;
#(
    parameter int IDX         = 0,
    parameter int VALUE_WIDTH = 16,
    parameter int AGE_WIDTH   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_bus              i_bus,
    input  logic [DATA_W-1:0] i_data,
    input  t_cand             i_cand,
    output t_cand             o_cand
);

    localparam int SW = (VALUE_WIDTH < DRIVE_W) ? VALUE_WIDTH : DRIVE_W;
    localparam int CW = (AGE_WIDTH > CFG_W) ? AGE_WIDTH : CFG_W;

    logic signed [CFG_W-1:0]  r_prio;
    logic [CFG_W-1:0]         r_tmo;
    logic                     r_has;
    logic [AGE_WIDTH-1:0]     r_age;
    logic [NUM_VALS-1:0][SW-1:0] r_val;

    logic                     hit;
    logic                     fresh;
    logic                     take;
    logic [DATA_W-1:0]        own_data;

    assign hit   = i_bus.store && (i_bus.src == SRC_W'(IDX));
    assign fresh = r_has && (CW'(r_age) <= CW'(r_tmo));
    assign take  = fresh && (!i_cand.vld || (r_prio > i_cand.prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= PRIO_RESET[IDX];
            r_tmo  <= TMO_RESET[IDX];
            r_has  <= 1'b0;
            r_age  <= '0;
        end else begin
            if (i_bus.cfg_we && i_bus.cfg_idx == CFG_IDX_W'(CFG_PRIO_BASE + IDX)) begin
                r_prio <= i_bus.cfg_data;
            end
            if (i_bus.cfg_we && i_bus.cfg_idx == CFG_IDX_W'(CFG_TMO_BASE + IDX)) begin
                r_tmo <= i_bus.cfg_data;
            end
            if (hit) begin
                r_has <= 1'b1;
                r_age <= '0;
            end else if (i_bus.tick && r_age != '1) begin
                r_age <= r_age + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            for (int k = 0; k < NUM_VALS; k++) begin
                r_val[k] <= i_data[k*DRIVE_W +: SW];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_VALS; k++) begin
            own_data[k*DRIVE_W +: DRIVE_W] = DRIVE_W'(signed'(r_val[k]));
        end
    end

    always_comb begin
        o_cand = i_cand;
        if (take) begin
            o_cand.vld  = 1'b1;
            o_cand.prio = r_prio;
            o_cand.idx  = SRC_W'(IDX);
            o_cand.data = own_data;
        end
    end

endmodule

// File: rtl/core/priority_command_mux_with_timeout.sv
// Priority command multiplexer with per-source timeout.
// Input stream (s side): tuser selects the operation and source, tdata
// carries five signed 16-bit drive values. A store item saves one source's
// values and restarts its age, a tick item ages every source (saturating),
// a publish item yields exactly one result item on the m side.
// Result: highest-priority source that holds a command and whose age is
// within its timeout; ties go to the lower index; all zero if none is fresh.
// Configuration: write port, index 0..3 priorities, 4..7 timeouts, taken
// at any edge with i_cfg_we high.
// Throughput: one item per cycle while o_s_tready is high. Each result is
// set by the compare chain through the source cells and is registered in
// the output register, or in the skid stage while the receiver stalls.
// Receiver stall: the output register holds its item and a one-entry skid
// stage takes the next result; o_s_tready falls only while the skid is full.
// Reset (synchronous, i_rst_n low): ages and command flags clear, the
// registers return to their defaults, the output side empties. No clearing
// pass is needed; the block accepts items the cycle after reset is released.
module priority_command_mux_with_timeout
    import pmux_pkg::*;
#(
    parameter int NUM_SOURCES = 3,
    parameter int VALUE_WIDTH = 16,
    parameter int AGE_WIDTH   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // in_speed, in_steer_angle, in_steer_rate, in_accel, in_jerk
    input  logic [DATA_W-1:0]    i_s_tdata,
    // func [1:0], source [3:2]
    input  logic [3:0]           i_s_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // out_speed, out_steer_angle, out_steer_rate, out_accel, out_jerk
    output logic [DATA_W-1:0]    o_m_tdata,
    // chosen_source [1:0], chosen_valid [2]
    output logic [2:0]           o_m_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_bus             bus;
    t_cand            cand [NUM_SOURCES+1];
    logic             acc;
    logic             pub;
    logic [FUNC_W-1:0] func;

    logic             r_out_vld;
    logic [DATA_W-1:0] r_out_data;
    logic [2:0]       r_out_user;
    logic             r_skid_vld;
    logic [DATA_W-1:0] r_skid_data;
    logic [2:0]       r_skid_user;
    logic [2:0]       res_user;

    assign o_s_tready = !r_skid_vld;
    assign acc  = i_s_tvalid && o_s_tready;
    assign func = i_s_tuser[FUNC_W-1:0];
    assign pub  = acc && (func == FUNC_PUBLISH);

    always_comb begin
        bus.store    = acc && (func == FUNC_STORE);
        bus.tick     = acc && (func == FUNC_TICK);
        bus.src      = i_s_tuser[FUNC_W +: SRC_W];
        bus.cfg_we   = i_cfg_we;
        bus.cfg_idx  = i_cfg_idx;
        bus.cfg_data = i_cfg_data;
    end

    assign cand[0] = '0;

    for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_cell
        pmux_cell #(
            .IDX         (g),
            .VALUE_WIDTH (VALUE_WIDTH),
            .AGE_WIDTH   (AGE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (bus),
            .i_data  (i_s_tdata),
            .i_cand  (cand[g]),
            .o_cand  (cand[g+1])
        );
    end

    assign res_user = {cand[NUM_SOURCES].vld, cand[NUM_SOURCES].idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (!r_out_vld || i_m_tready) begin
                r_out_vld <= r_skid_vld || pub;
            end
            if (r_skid_vld) begin
                if (i_m_tready) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (pub && r_out_vld && !i_m_tready) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_m_tready) begin
            if (r_skid_vld) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end else begin
                r_out_data <= cand[NUM_SOURCES].data;
                r_out_user <= res_user;
            end
        end
        if (pub && r_out_vld && !i_m_tready) begin
            r_skid_data <= cand[NUM_SOURCES].data;
            r_skid_user <= res_user;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

// File: rtl/core/pmux_chk.sv
module pmux_chk
    import pmux_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [3:0]           i_s_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready,
    input logic [DATA_W-1:0]    o_m_tdata,
    input logic [2:0]           o_m_tuser
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled item changed");

    a_neutral_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[2] |-> o_m_tdata == '0 && o_m_tuser[1:0] == 2'd0)
        else $error("neutral item not all zero");

    a_from_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |->
            $past(i_s_tvalid && o_s_tready && i_s_tuser[1:0] == FUNC_PUBLISH))
        else $error("result without publish");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind priority_command_mux_with_timeout pmux_chk u_pmux_chk (.*);

// File: test/tb_top.sv
module tb_top;
    import pmux_pkg::*;

    localparam int N_SRC       = 3;
    localparam int AGE_W       = 16;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [3:0]        user;
        logic [DATA_W-1:0] data;
    } stim_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic [SRC_W-1:0]  src;
        logic              vld;
    } pick_t;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic [DATA_W-1:0]    i_s_tdata  = '0;
    logic [3:0]           i_s_tuser  = '0;
    logic                 i_m_tready = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [DATA_W-1:0]    o_m_tdata;
    logic [2:0]           o_m_tuser;

    stim_item_t stim_q [$];
    pick_t      pick_q [$];

    logic signed [CFG_W-1:0] prio_cfg [NUM_SLOTS];
    logic [CFG_W-1:0]        tmo_cfg  [NUM_SLOTS];
    logic [DATA_W-1:0]       held_cmd [NUM_SLOTS];
    bit                      has_cmd  [NUM_SLOTS];
    logic [AGE_W-1:0]        age_cnt  [NUM_SLOTS];

    string drive_names [NUM_VALS] = '{
        "out_speed", "out_steer_angle", "out_steer_rate", "out_accel", "out_jerk"
    };

    int  err_cnt      = 0;
    int  cycle_cnt    = 0;
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    int  hold_req     = 0;
    int  hold_done    = 0;
    int  hold_cnt     = 0;
    bit  in_taken     = 1'b0;

    priority_command_mux_with_timeout #(
        .NUM_SOURCES(N_SRC),
        .VALUE_WIDTH(DRIVE_W),
        .AGE_WIDTH  (AGE_W)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    task automatic arbitrate(input logic [3:0] user, input logic [DATA_W-1:0] data);
        logic [FUNC_W-1:0] op;
        logic [SRC_W-1:0]  src;
        int                best;
        pick_t             p;
        op  = user[1:0];
        src = user[3:2];
        case (op)
            FUNC_STORE: begin
                if (src < N_SRC) begin
                    held_cmd[src] = data;
                    age_cnt[src]  = '0;
                    has_cmd[src]  = 1'b1;
                end
            end
            FUNC_TICK: begin
                for (int i = 0; i < N_SRC; i++)
                    if (age_cnt[i] < AGE_MAX) age_cnt[i]++;
            end
            FUNC_PUBLISH: begin
                best = -1;
                for (int i = 0; i < N_SRC; i++) begin
                    if (has_cmd[i] && age_cnt[i] <= tmo_cfg[i]) begin
                        if (best < 0 || prio_cfg[i] > prio_cfg[best]) best = i;
                    end
                end
                p.drive = (best >= 0) ? held_cmd[best] : '0;
                p.src   = (best >= 0) ? best[SRC_W-1:0] : '0;
                p.vld   = (best >= 0);
                pick_q.push_back(p);
            end
            default: ;
        endcase
    endtask

    task automatic check_pick(input logic [DATA_W-1:0] drive, input logic [2:0] user);
        pick_t want;
        if (pick_q.size() == 0) begin
            $error("unexpected result item: tdata %h tuser %h", drive, user);
            err_cnt++;
            return;
        end
        want = pick_q.pop_front();
        for (int k = 0; k < NUM_VALS; k++) begin
            if (drive[k*DRIVE_W +: DRIVE_W] !== want.drive[k*DRIVE_W +: DRIVE_W]) begin
                $error("%s: expected %0d, got %0d", drive_names[k],
                       $signed(want.drive[k*DRIVE_W +: DRIVE_W]),
                       $signed(drive[k*DRIVE_W +: DRIVE_W]));
                err_cnt++;
            end
        end
        if (user[1:0] !== want.src) begin
            $error("chosen_source: expected %0d, got %0d", want.src, user[1:0]);
            err_cnt++;
        end
        if (user[2] !== want.vld) begin
            $error("chosen_valid: expected %0d, got %0d", want.vld, user[2]);
            err_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                in_taken = 1'b1;
                arbitrate(i_s_tuser, i_s_tdata);
            end
            if (o_m_tvalid && i_m_tready) check_pick(o_m_tdata, o_m_tuser);
        end
    end

    always @(negedge i_clk) begin
        stim_item_t it;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (i_s_tvalid && !in_taken) begin
        end else if (stim_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            it = stim_q.pop_front();
            i_s_tuser  <= it.user;
            i_s_tdata  <= it.data;
            i_s_tvalid <= 1'b1;
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_m_tready <= 1'b0;
        end else if (hold_done < hold_req) begin
            hold_done++;
            hold_cnt = LONG_HOLD - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] rand_drive();
        logic [DATA_W-1:0]  v;
        logic [DRIVE_W-1:0] f;
        for (int k = 0; k < NUM_VALS; k++) begin
            case ($urandom_range(7))
                0:       f = 16'h8000;
                1:       f = 16'h7FFF;
                2:       f = 16'h0000;
                3:       f = 16'hFFFF;
                default: f = DRIVE_W'($urandom);
            endcase
            v[k*DRIVE_W +: DRIVE_W] = f;
        end
        return v;
    endfunction

    task automatic push_op(input logic [FUNC_W-1:0] op, input logic [SRC_W-1:0] src,
                           input logic [DATA_W-1:0] vals);
        stim_item_t it;
        it.user = {src, op};
        it.data = vals;
        stim_q.push_back(it);
    endtask

    task automatic gen_traffic(input int n_items, input int tick_span);
        int               made;
        int               r;
        int               burst;
        logic [SRC_W-1:0] src;
        made = 0;
        while (made < n_items) begin
            r   = $urandom_range(99);
            src = SRC_W'($urandom_range(3));
            if (r < 30) begin
                push_op(FUNC_STORE, src, rand_drive());
                if (src < N_SRC) made++;
            end else if (r < 55) begin
                burst = $urandom_range(tick_span, 1);
                for (int j = 0; j < burst; j++)
                    push_op(FUNC_TICK, SRC_W'($urandom_range(3)), rand_drive());
                made += burst;
            end else if (r < 93) begin
                push_op(FUNC_PUBLISH, src, rand_drive());
                made++;
            end else begin
                push_op(FUNC_NONE, src, rand_drive());
            end
        end
    endtask

    task automatic drain();
        do @(negedge i_clk); while (stim_q.size() != 0 || i_s_tvalid || pick_q.size() != 0);
    endtask

    task automatic write_reg(input int idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[CFG_IDX_W-1:0];
        i_cfg_data <= val;
        if (idx < CFG_TMO_BASE) prio_cfg[idx - CFG_PRIO_BASE] = val;
        else                    tmo_cfg[idx - CFG_TMO_BASE]  = val;
        @(negedge i_clk);
    endtask

    task automatic setup_regs(input logic [CFG_W-1:0] p0, p1, p2, p3, t0, t1, t2, t3);
        drain();
        repeat (4) @(negedge i_clk);
        write_reg(CFG_PRIO_BASE + 0, p0);
        write_reg(CFG_PRIO_BASE + 1, p1);
        write_reg(CFG_PRIO_BASE + 2, p2);
        write_reg(CFG_PRIO_BASE + 3, p3);
        write_reg(CFG_TMO_BASE + 0, t0);
        write_reg(CFG_TMO_BASE + 1, t1);
        write_reg(CFG_TMO_BASE + 2, t2);
        write_reg(CFG_TMO_BASE + 3, t3);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            prio_cfg[i] = PRIO_RESET[i];
            tmo_cfg[i]  = TMO_RESET[i];
            held_cmd[i] = '0;
            has_cmd[i]  = 1'b0;
            age_cnt[i]  = '0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty mux, ignored codes, extremes, priority order
        push_op(FUNC_PUBLISH, 2'd0, '0);
        push_op(FUNC_NONE, 2'd3, '1);
        push_op(FUNC_STORE, 2'd3, {NUM_VALS{16'h7FFF}});
        push_op(FUNC_PUBLISH, 2'd3, '1);
        push_op(FUNC_STORE, 2'd2, {NUM_VALS{16'h8000}});
        push_op(FUNC_PUBLISH, 2'd1, '0);
        push_op(FUNC_STORE, 2'd1, {NUM_VALS{16'h7FFF}});
        push_op(FUNC_PUBLISH, 2'd2, '0);
        push_op(FUNC_STORE, 2'd0, {5{16'hFFFF}} ^ {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
        push_op(FUNC_PUBLISH, 2'd0, '0);
        push_op(FUNC_TICK, 2'd3, '1);
        push_op(FUNC_PUBLISH, 2'd0, '0);
        push_op(FUNC_STORE, 2'd0, '0);
        push_op(FUNC_STORE, 2'd1, {NUM_VALS{16'h0001}});
        push_op(FUNC_PUBLISH, 2'd3, '1);
        push_op(FUNC_TICK, 2'd0, '0);
        push_op(FUNC_PUBLISH, 2'd0, '0);
        gen_traffic(200, 60);

        setup_regs(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'd0, 16'hFFFF, 16'd5, 16'd20);
        tx_idle_pct = 62;
        gen_traffic(230, 6);

        setup_regs(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'd3, 16'd10, 16'd0, 16'hFFFF);
        tx_idle_pct  = 0;
        rx_stall_pct = 62;
        gen_traffic(230, 6);

        setup_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                   CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)),
                   CFG_W'($urandom_range(15)), CFG_W'($urandom_range(15)));
        tx_idle_pct  = 9;
        rx_stall_pct = 9;
        gen_traffic(230, 5);

        setup_regs(16'sd0, 16'sd0, 16'sd1, 16'sh7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req++;
        for (int i = 0; i < 60; i++) begin
            if (i % 4 == 0) push_op(FUNC_STORE, SRC_W'($urandom_range(3)), rand_drive());
            else            push_op(FUNC_PUBLISH, SRC_W'($urandom_range(3)), rand_drive());
        end

        setup_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                   16'hFFFF, 16'd0, 16'd100, CFG_W'($urandom_range(40)));
        gen_traffic(100, 20);

        // sources drop out one by one at their timeout
        setup_regs(16'sd4, 16'sd3, 16'sd2, 16'sd1, 16'd9, 16'd10, 16'd100, 16'd0);
        for (int i = 0; i < N_SRC; i++) push_op(FUNC_STORE, SRC_W'(i), rand_drive());
        for (int i = 0; i < 9; i++) push_op(FUNC_TICK, SRC_W'($urandom_range(3)), rand_drive());
        push_op(FUNC_PUBLISH, 2'd0, '0);
        push_op(FUNC_TICK, 2'd0, '0);
        push_op(FUNC_PUBLISH, 2'd0, '0);
        push_op(FUNC_TICK, 2'd0, '0);
        push_op(FUNC_PUBLISH, 2'd0, '0);
        push_op(FUNC_STORE, 2'd0, rand_drive());
        push_op(FUNC_PUBLISH, 2'd0, '0);

        drain();
        repeat (8) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/pmux_pkg.sv
rtl/core/pmux_cell.sv
rtl/core/priority_command_mux_with_timeout.sv
rtl/core/pmux_chk.sv
test/tb_top.sv
